// ----- design/assert_macros.svh -----
// Assertion macros used by the checker file of this project.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Concurrent assertion on the rising clock edge, disabled while reset is low.
`define PTED_ASSERT(lbl, clk, rstn, prop) \
  lbl: assert property (@(posedge clk) disable iff (!(rstn)) (prop)) \
    else $error("planar tile encoder check failed");

// Concurrent assertion on the rising clock edge that also holds during reset.
`define PTED_ASSERT_ALWAYS(lbl, clk, prop) \
  lbl: assert property (@(posedge clk) (prop)) \
    else $error("planar tile encoder check failed");

`endif

// ----- design/pted_pkg.sv -----
// Package with the constants, payload types and state type of the tile encoder.
`default_nettype none

package pted_pkg;

  localparam int unsigned MaxTiles    = 256;
  localparam int unsigned IdxW        = $clog2(MaxTiles);
  localparam int unsigned CntW        = $clog2(MaxTiles + 1);
  localparam int unsigned CapW        = 9;
  localparam int unsigned RowW        = 16;
  localparam int unsigned TileIdxW    = 8;
  localparam int unsigned PixPerRow   = 8;
  localparam int unsigned RowsPerTile = 8;
  localparam int unsigned RowCntW     = $clog2(RowsPerTile);
  localparam int unsigned PlaneW      = PixPerRow * RowsPerTile;
  localparam int unsigned CmpW        = ((CapW > CntW) ? CapW : CntW) + 1;

  typedef enum logic {
    ReqClear = 1'b0,
    ReqRow   = 1'b1
  } req_type_e;

  typedef enum logic [1:0] {
    StIdle   = 2'd0,
    StSearch = 2'd1,
    StDone   = 2'd2
  } state_e;

  typedef struct packed {
    logic            req_type;
    logic [RowW-1:0] row_pixels;
  } req_t;

  typedef struct packed {
    logic [TileIdxW-1:0] tile_index;
    logic                is_new;
    logic                bank_full;
    logic [PlaneW-1:0]   plane_low;
    logic [PlaneW-1:0]   plane_high;
  } res_t;

endpackage

`default_nettype wire

// ----- design/pted_req_if.sv -----
// Request channel interface: valid, ready and one request item.
`default_nettype none

interface pted_req_if;
  import pted_pkg::*;

  logic valid;
  logic ready;
  req_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

`default_nettype wire

// ----- design/pted_res_if.sv -----
// Result channel interface: valid, ready and one result item.
`default_nettype none

interface pted_res_if;
  import pted_pkg::*;

  logic valid;
  logic ready;
  res_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

`default_nettype wire

// ----- design/planar_tile_encode_dedup_core.sv -----
// Top level of the planar 2bpp tile encoder with a bank of unique tiles.
//
// Usage: each transfer on req_i carries either a clear request (req_type 0)
// or one row of eight 2-bit pixels (req_type 1). Rows are packed into a low
// and a high bit plane; after the eighth row of a tile the bank is searched
// and one transfer on res_o reports the tile index, the new/full flags and
// both planes. Rows one to seven and clear requests produce no result.
// The capacity register is written through cfg_we_i/cfg_wdata_i; the user
// must write it only while the block is idle, which the block does not enforce.
// Values above the bank size saturate to the bank size. Rows one to seven
// and clears are taken while the block is idle. The eighth row starts a
// search that reads the tile memory one entry per cycle through its single
// read port and holds req_i.ready low until the result of the search is
// loaded into the output register.
// Results sit in an output register; rows are still taken while a result
// waits, and only the end of a search stalls until the register is free.
// Reset empties the bank, drops any partial tile and sets the capacity
// to the full bank; the tile memory itself is not cleared.
`default_nettype none

module planar_tile_encode_dedup_core (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      cfg_we_i,
  input  logic [pted_pkg::CapW-1:0] cfg_wdata_i,
  pted_req_if.sink                  req_i,
  pted_res_if.source                res_o
);
  import pted_pkg::*;

  // Control state.
  state_e               state_q, state_d;
  logic [RowCntW-1:0]   row_q, row_d;
  logic [PlaneW-1:0]    acc_lo_q, acc_lo_d;
  logic [PlaneW-1:0]    acc_hi_q, acc_hi_d;
  logic [CntW-1:0]      count_q, count_d;
  logic [CapW-1:0]      cap_q;
  logic                 res_vld_q, res_vld_d;
  logic                 cmp_vld_q, cmp_vld_d;
  logic                 hit_q, hit_d;

  // Payload registers.
  logic [2*PlaneW-1:0]  tile_q, tile_d;
  logic [CntW-1:0]      scan_q, scan_d;
  logic [IdxW-1:0]      cmp_idx_q, cmp_idx_d;
  logic [IdxW-1:0]      hit_idx_q, hit_idx_d;
  res_t                 res_q, res_d;

  // Tile memory with one write and one registered read port.
  logic [2*PlaneW-1:0]  tile_mem_q [MaxTiles];
  logic [2*PlaneW-1:0]  rd_data_q;
  logic                 mem_we, mem_re;
  logic [IdxW-1:0]      rd_addr;

  logic                 req_xfer;
  logic                 out_free;
  logic                 last_row;
  logic                 match;
  logic                 more;
  logic                 room;
  logic                 res_load;
  logic [CmpW-1:0]      cap_ext, cap_eff;
  logic [PixPerRow-1:0] lo_byte, hi_byte;
  logic [PlaneW-1:0]    ins_lo, ins_hi;

  assign req_xfer = req_i.valid && req_i.ready;
  assign out_free = !res_vld_q || res_o.ready;
  assign last_row = (row_q == RowCntW'(RowsPerTile - 1));
  assign match    = cmp_vld_q && (rd_data_q == tile_q);
  assign more     = (scan_q < count_q);
  assign rd_addr  = scan_q[IdxW-1:0];

  // Effective capacity saturates at the bank size.
  assign cap_ext = CmpW'(cap_q);
  assign cap_eff = (cap_ext > CmpW'(MaxTiles)) ? CmpW'(MaxTiles) : cap_ext;
  assign room    = (CmpW'(count_q) < cap_eff);

  // Pixel x of the row lands at bit 7-x of each plane byte.
  always_comb begin
    for (int x = 0; x < PixPerRow; x++) begin
      lo_byte[PixPerRow-1-x] = req_i.data.row_pixels[2*x];
      hi_byte[PixPerRow-1-x] = req_i.data.row_pixels[2*x+1];
    end
  end

  // The accumulators start at zero, so writing the byte equals OR-ing it in.
  always_comb begin
    ins_lo = acc_lo_q;
    ins_hi = acc_hi_q;
    ins_lo[{row_q, 3'b000} +: PixPerRow] = lo_byte;
    ins_hi[{row_q, 3'b000} +: PixPerRow] = hi_byte;
  end

  // Next state.
  always_comb begin
    state_d = state_q;
    case (state_q)
      StIdle: begin
        if (req_xfer && (req_i.data.req_type == ReqRow) && last_row) begin
          state_d = StSearch;
        end
      end
      StSearch: begin
        if (match || (!more && !cmp_vld_q)) begin
          state_d = StDone;
        end
      end
      StDone: begin
        if (out_free) begin
          state_d = StIdle;
        end
      end
      default: state_d = StIdle;
    endcase
  end

  // Datapath control and outputs.
  always_comb begin
    req_i.ready = 1'b0;
    row_d       = row_q;
    acc_lo_d    = acc_lo_q;
    acc_hi_d    = acc_hi_q;
    count_d     = count_q;
    tile_d      = tile_q;
    scan_d      = scan_q;
    cmp_vld_d   = 1'b0;
    cmp_idx_d   = cmp_idx_q;
    hit_d       = hit_q;
    hit_idx_d   = hit_idx_q;
    mem_we      = 1'b0;
    mem_re      = 1'b0;
    res_load    = 1'b0;
    res_d       = res_q;
    case (state_q)
      StIdle: begin
        req_i.ready = 1'b1;
        if (req_xfer) begin
          if (req_i.data.req_type == ReqClear) begin
            count_d  = '0;
            row_d    = '0;
            acc_lo_d = '0;
            acc_hi_d = '0;
          end else if (last_row) begin
            tile_d   = {ins_hi, ins_lo};
            row_d    = '0;
            acc_lo_d = '0;
            acc_hi_d = '0;
            scan_d   = '0;
            hit_d    = 1'b0;
          end else begin
            row_d    = row_q + 1'b1;
            acc_lo_d = ins_lo;
            acc_hi_d = ins_hi;
          end
        end
      end
      StSearch: begin
        // One memory read per cycle; each compare runs in the cycle after its read.
        if (match) begin
          hit_d     = 1'b1;
          hit_idx_d = cmp_idx_q;
        end else if (more) begin
          mem_re    = 1'b1;
          scan_d    = scan_q + 1'b1;
          cmp_vld_d = 1'b1;
          cmp_idx_d = scan_q[IdxW-1:0];
        end
      end
      StDone: begin
        if (out_free) begin
          res_load              = 1'b1;
          res_d.plane_low       = tile_q[PlaneW-1:0];
          res_d.plane_high      = tile_q[2*PlaneW-1:PlaneW];
          res_d.is_new          = !hit_q && room;
          res_d.bank_full       = !hit_q && !room;
          if (hit_q) begin
            res_d.tile_index = TileIdxW'(hit_idx_q);
          end else if (room) begin
            res_d.tile_index = TileIdxW'(count_q);
            mem_we           = 1'b1;
            count_d          = count_q + 1'b1;
          end else begin
            res_d.tile_index = '0;
          end
        end
      end
      default: ;
    endcase
  end

  always_comb begin
    if (res_load) begin
      res_vld_d = 1'b1;
    end else if (res_o.ready) begin
      res_vld_d = 1'b0;
    end else begin
      res_vld_d = res_vld_q;
    end
  end

  assign res_o.valid = res_vld_q;
  assign res_o.data  = res_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= StIdle;
      row_q     <= '0;
      acc_lo_q  <= '0;
      acc_hi_q  <= '0;
      count_q   <= '0;
      cap_q     <= CapW'(MaxTiles);
      res_vld_q <= 1'b0;
      cmp_vld_q <= 1'b0;
      hit_q     <= 1'b0;
    end else begin
      state_q   <= state_d;
      row_q     <= row_d;
      acc_lo_q  <= acc_lo_d;
      acc_hi_q  <= acc_hi_d;
      count_q   <= count_d;
      res_vld_q <= res_vld_d;
      cmp_vld_q <= cmp_vld_d;
      hit_q     <= hit_d;
      if (cfg_we_i) begin
        cap_q <= cfg_wdata_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    tile_q    <= tile_d;
    scan_q    <= scan_d;
    cmp_idx_q <= cmp_idx_d;
    hit_idx_q <= hit_idx_d;
    res_q     <= res_d;
  end

  // New tiles are written at the current fill count, which is below the bank size.
  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      tile_mem_q[count_q[IdxW-1:0]] <= tile_q;
    end
    if (mem_re) begin
      rd_data_q <= tile_mem_q[rd_addr];
    end
  end

endmodule

`default_nettype wire

// ----- design/pted_chk.sv -----
// Port-level checker for the tile encoder and its bind to the top level.
`default_nettype none

`include "assert_macros.svh"

module pted_chk (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           req_valid_i,
  input  logic           req_ready_i,
  input  logic           res_valid_i,
  input  logic           res_ready_i,
  input  pted_pkg::res_t res_data_i
);
  import pted_pkg::*;

  // A stalled result keeps its contents.
  `PTED_ASSERT(a_res_hold, clk_i, rst_ni, res_valid_i && !res_ready_i |=> res_valid_i && $stable(res_data_i))

  // A tile is never both appended and refused.
  `PTED_ASSERT(a_new_xor_full, clk_i, rst_ni, !(res_valid_i && res_data_i.is_new && res_data_i.bank_full))

  // A refused tile reports index zero.
  `PTED_ASSERT(a_full_index, clk_i, rst_ni, res_valid_i && res_data_i.bank_full |-> res_data_i.tile_index == '0)

  // The request side goes busy only after it took a transfer.
  `PTED_ASSERT(a_busy_after_xfer, clk_i, rst_ni, $fell(req_ready_i) |-> $past(req_valid_i))

  // A fresh result only appears at the end of a search, while requests are held off.
  `PTED_ASSERT(a_res_after_search, clk_i, rst_ni, $rose(res_valid_i) |-> !$past(req_ready_i))

endmodule

bind planar_tile_encode_dedup_core pted_chk u_pted_chk (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .req_valid_i (req_i.valid),
  .req_ready_i (req_i.ready),
  .res_valid_i (res_o.valid),
  .res_ready_i (res_o.ready),
  .res_data_i  (res_o.data)
);

`default_nettype wire
